### hw/rtl/dsbc_pkg.sv
// dsbc_pkg: shared types and codes for the dual slot boot controller
// no dependencies; used by every rtl file of the block except dsbc_ifs

package dsbc_pkg;

    // event codes on req_type
    localparam logic [2:0] REQ_INIT    = 3'd0;
    localparam logic [2:0] REQ_STAGE   = 3'd1;
    localparam logic [2:0] REQ_UPGRADE = 3'd2;
    localparam logic [2:0] REQ_REBOOT  = 3'd3;
    localparam logic [2:0] REQ_CONFIRM = 3'd4;

    // upgrade modes, also the pending kind
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_TEST = 2'd1;
    localparam logic [1:0] MODE_PERM = 2'd2;

    // reboot outcome
    localparam logic [1:0] SWAP_NONE     = 2'd0;
    localparam logic [1:0] SWAP_ROLLBACK = 2'd1;
    localparam logic [1:0] SWAP_UPGRADE  = 2'd2;

    localparam int VersionWidth = 24;

    // one captured request item
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [7:0]  ver_patch;
        logic [31:0] image_crc;
        logic [31:0] image_size;
        logic        image_valid;
        logic [1:0]  upgrade_mode;
    } item_t;

    // one result item
    typedef struct packed {
        logic        accepted;
        logic [1:0]  swap_kind;
        logic [7:0]  primary_major;
        logic [7:0]  primary_minor;
        logic [7:0]  primary_patch;
        logic [31:0] primary_crc;
        logic [31:0] primary_size;
        logic        primary_confirmed;
        logic        trial_active;
        logic        upgrade_pending;
    } result_t;

    // one firmware slot record
    typedef struct packed {
        logic [VersionWidth-1:0] version;
        logic [31:0]             crc;
        logic [31:0]             size;
        logic                    valid;
        logic                    confirmed;
    } slot_t;

endpackage

### hw/rtl/dsbc_ifs.sv
// dsbc_req_if, dsbc_rsp_if: valid/ready channels of the boot controller
// standalone; field widths follow dsbc_pkg item_t and result_t

interface dsbc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
    logic [7:0]  ver_patch;
    logic [31:0] image_crc;
    logic [31:0] image_size;
    logic        image_valid;
    logic [1:0]  upgrade_mode;

    modport source (
        output valid, req_type, ver_major, ver_minor, ver_patch,
               image_crc, image_size, image_valid, upgrade_mode,
        input  ready
    );
    modport sink (
        input  valid, req_type, ver_major, ver_minor, ver_patch,
               image_crc, image_size, image_valid, upgrade_mode,
        output ready
    );
endinterface

interface dsbc_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  swap_kind;
    logic [7:0]  primary_major;
    logic [7:0]  primary_minor;
    logic [7:0]  primary_patch;
    logic [31:0] primary_crc;
    logic [31:0] primary_size;
    logic        primary_confirmed;
    logic        trial_active;
    logic        upgrade_pending;

    modport source (
        output valid, accepted, swap_kind, primary_major, primary_minor,
               primary_patch, primary_crc, primary_size, primary_confirmed,
               trial_active, upgrade_pending,
        input  ready
    );
    modport sink (
        input  valid, accepted, swap_kind, primary_major, primary_minor,
               primary_patch, primary_crc, primary_size, primary_confirmed,
               trial_active, upgrade_pending,
        output ready
    );
endinterface

### hw/rtl/dsbc_in_reg.sv
// dsbc_in_reg: input register stage of the boot controller
// depends on dsbc_pkg and dsbc_req_if

module dsbc_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    dsbc_req_if.sink          req,
    input  logic              adv,
    output logic              vld,
    output dsbc_pkg::item_t   item
);
    import dsbc_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    logic  take;

    // stage is free when empty or when its item moves on this cycle
    assign req.ready = !vld_reg || adv;
    assign take      = req.valid && req.ready;

    // occupancy
    always_comb
    begin
        if (take)
            vld_next = 1'b1;
        else if (adv)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.req_type     <= req.req_type;
            item_reg.ver_major    <= req.ver_major;
            item_reg.ver_minor    <= req.ver_minor;
            item_reg.ver_patch    <= req.ver_patch;
            item_reg.image_crc    <= req.image_crc;
            item_reg.image_size   <= req.image_size;
            item_reg.image_valid  <= req.image_valid;
            item_reg.upgrade_mode <= req.upgrade_mode;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;
endmodule

### hw/rtl/dsbc_slot_ctrl.sv
// dsbc_slot_ctrl: slot records, upgrade flags and the per-event update
// depends on dsbc_pkg

module dsbc_slot_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dsbc_pkg::item_t   item,
    output dsbc_pkg::result_t res
);
    import dsbc_pkg::*;

    slot_t      prim_reg, prim_next;
    slot_t      sec_reg, sec_next;
    logic       pending_reg, pending_next;
    logic [1:0] kind_reg, kind_next;
    logic       trial_reg, trial_next;
    logic       accepted;
    logic [1:0] swap_kind;
    logic [VersionWidth-1:0] cand_ver;
    logic       mode_ok;

    assign cand_ver = {item.ver_major, item.ver_minor, item.ver_patch};
    assign mode_ok  = (item.upgrade_mode == MODE_TEST) || (item.upgrade_mode == MODE_PERM);

    // next state for the event in the input register
    always_comb
    begin
        prim_next    = prim_reg;
        sec_next     = sec_reg;
        pending_next = pending_reg;
        kind_next    = kind_reg;
        trial_next   = trial_reg;
        accepted     = 1'b1;
        swap_kind    = SWAP_NONE;
        case (item.req_type)
            REQ_INIT:
            begin
                prim_next.version   = cand_ver;
                prim_next.crc       = item.image_crc;
                prim_next.size      = item.image_size;
                prim_next.valid     = 1'b1;
                prim_next.confirmed = 1'b1;
                sec_next.valid      = 1'b0;
                sec_next.confirmed  = 1'b0;
                pending_next        = 1'b0;
                kind_next           = MODE_NONE;
                trial_next          = 1'b0;
            end
            REQ_STAGE:
            begin
                if (!item.image_valid)
                    accepted = 1'b0;
                else
                begin
                    sec_next.version   = cand_ver;
                    sec_next.crc       = item.image_crc;
                    sec_next.size      = item.image_size;
                    sec_next.valid     = 1'b1;
                    sec_next.confirmed = 1'b0;
                    pending_next       = 1'b0;
                    kind_next          = MODE_NONE;
                end
            end
            REQ_UPGRADE:
            begin
                if (!sec_reg.valid || !mode_ok || (sec_reg.version <= prim_reg.version))
                    accepted = 1'b0;
                else
                begin
                    pending_next = 1'b1;
                    kind_next    = item.upgrade_mode;
                end
            end
            REQ_REBOOT:
            begin
                // rollback of an unconfirmed trial boot wins over a pending swap
                if (trial_reg && !prim_reg.confirmed && sec_reg.valid)
                begin
                    prim_next           = sec_reg;
                    sec_next            = prim_reg;
                    prim_next.confirmed = 1'b1;
                    trial_next          = 1'b0;
                    pending_next        = 1'b0;
                    kind_next           = MODE_NONE;
                    swap_kind           = SWAP_ROLLBACK;
                end
                else if (pending_reg && sec_reg.valid)
                begin
                    prim_next           = sec_reg;
                    sec_next            = prim_reg;
                    prim_next.confirmed = (kind_reg == MODE_PERM);
                    trial_next          = (kind_reg == MODE_TEST);
                    pending_next        = 1'b0;
                    kind_next           = MODE_NONE;
                    swap_kind           = SWAP_UPGRADE;
                end
            end
            REQ_CONFIRM:
            begin
                prim_next.confirmed = 1'b1;
                trial_next          = 1'b0;
            end
            default:
            begin
                accepted = 1'b0;
            end
        endcase
    end

    // state registers update only when the event moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_reg    <= '0;
            sec_reg     <= '0;
            pending_reg <= 1'b0;
            kind_reg    <= MODE_NONE;
            trial_reg   <= 1'b0;
        end
        else if (fire)
        begin
            prim_reg    <= prim_next;
            sec_reg     <= sec_next;
            pending_reg <= pending_next;
            kind_reg    <= kind_next;
            trial_reg   <= trial_next;
        end
    end

    // result reports the primary slot after the event
    always_comb
    begin
        res.accepted          = accepted;
        res.swap_kind         = swap_kind;
        res.primary_major     = prim_next.version[23:16];
        res.primary_minor     = prim_next.version[15:8];
        res.primary_patch     = prim_next.version[7:0];
        res.primary_crc       = prim_next.crc;
        res.primary_size      = prim_next.size;
        res.primary_confirmed = prim_next.confirmed;
        res.trial_active      = trial_next;
        res.upgrade_pending   = pending_next;
    end
endmodule

### hw/rtl/dsbc_out_reg.sv
// dsbc_out_reg: result register stage of the boot controller
// depends on dsbc_pkg and dsbc_rsp_if

module dsbc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    dsbc_rsp_if.source        rsp,
    input  logic              load,
    input  dsbc_pkg::result_t res,
    output logic              adv
);
    import dsbc_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // free when empty or when the held item is taken
    assign adv = !vld_reg || rsp.ready;

    always_comb
    begin
        if (load)
            vld_next = 1'b1;
        else if (rsp.ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    // drive the channel
    assign rsp.valid             = vld_reg;
    assign rsp.accepted          = res_reg.accepted;
    assign rsp.swap_kind         = res_reg.swap_kind;
    assign rsp.primary_major     = res_reg.primary_major;
    assign rsp.primary_minor     = res_reg.primary_minor;
    assign rsp.primary_patch     = res_reg.primary_patch;
    assign rsp.primary_crc       = res_reg.primary_crc;
    assign rsp.primary_size      = res_reg.primary_size;
    assign rsp.primary_confirmed = res_reg.primary_confirmed;
    assign rsp.trial_active      = res_reg.trial_active;
    assign rsp.upgrade_pending   = res_reg.upgrade_pending;
endmodule

### hw/rtl/dual_slot_boot_controller_unit.sv
// dual_slot_boot_controller_unit: top level of the a/b slot boot controller
// depends on dsbc_pkg, dsbc_ifs, dsbc_in_reg, dsbc_slot_ctrl, dsbc_out_reg
//
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, version, image_crc/size/valid, upgrade_mode
// rsp      out  valid/ready    accepted, swap_kind, primary slot, trial/pending flags
//
// one item per cycle sustained while rsp.ready stays high; an accepted item sits
// in the input register and is updated against the slot registers on its way
// into the result register, which then drives rsp.valid and the result; the
// item moves on only when the result register is free.
// reset clears both slot records and all flags.
// a stalled result holds the pipeline; an empty input register still takes an item.

module dual_slot_boot_controller_unit (
    input  logic       clk,
    input  logic       rst_n,
    dsbc_req_if.sink   req,
    dsbc_rsp_if.source rsp
);
    import dsbc_pkg::*;

    logic    in_vld;
    item_t   item;
    logic    adv;
    logic    fire;
    result_t res;

    // an event moves on when it is present and the result stage is free
    assign fire = in_vld && adv;

    dsbc_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .adv   (adv),
        .vld   (in_vld),
        .item  (item)
    );

    dsbc_slot_ctrl u_slot_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res)
    );

    dsbc_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .rsp   (rsp),
        .load  (fire),
        .res   (res),
        .adv   (adv)
    );
endmodule
